>>> src/exchange_sort_up_down_defines.svh
// assertion macros used by the checker file
`ifndef EXCHANGE_SORT_UP_DOWN_DEFINES_SVH
`define EXCHANGE_SORT_UP_DOWN_DEFINES_SVH

// same-cycle implication
`define EXSORT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EXSORT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/exsort_pkg.sv
package exsort_pkg;

   localparam int EXSORT_DEPTH  = 16;
   localparam int EXSORT_DATA_W = 32;
   localparam int EXSORT_IDX_W  = $clog2(EXSORT_DEPTH);
   localparam int EXSORT_CNT_W  = $clog2(EXSORT_DEPTH + 1);

   typedef struct packed {
      logic signed [EXSORT_DATA_W-1:0] held;
      logic signed [EXSORT_DATA_W-1:0] probe;
      logic                            descending;
   } exsort_cmp_req_type;

endpackage

>>> src/exsort_cmp.sv
module exsort_cmp import exsort_pkg::*; (
   input  exsort_cmp_req_type cmp_req,
   output logic               cmp_swap
);

   // held sits at the lower position, probe at a later one
   always_comb begin
      if (cmp_req.descending) begin
         cmp_swap = cmp_req.held < cmp_req.probe;
      end else begin
         cmp_swap = cmp_req.held > cmp_req.probe;
      end
   end

endmodule

>>> src/exsort_seq.sv
module exsort_seq import exsort_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [EXSORT_DATA_W-1:0] req_tdata,
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [EXSORT_DATA_W-1:0] rsp_tdata,
   output logic                     rsp_tlast,
   output logic [0:0]               rsp_tuser,
   input  logic                     csr_we,
   input  logic [0:0]               csr_wdata,
   output exsort_cmp_req_type       cmp_req,
   input  logic                     cmp_swap
);

   typedef enum logic [7:0] {
      ST_COLLECT = 8'b0000_0001,
      ST_LOAD    = 8'b0000_0010,
      ST_PRIME   = 8'b0000_0100,
      ST_SCAN    = 8'b0000_1000,
      ST_WRI     = 8'b0001_0000,
      ST_EM_RD   = 8'b0010_0000,
      ST_EM_WAIT = 8'b0100_0000,
      ST_EM_OUT  = 8'b1000_0000
   } exsort_state_type;

   exsort_state_type state_ff, state_in;

   logic [EXSORT_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                     drop_ff, drop_in;
   logic                     desc_ff, desc_in;
   logic [EXSORT_IDX_W-1:0]  i_ff, i_in;
   logic [EXSORT_CNT_W-1:0]  j_ff, j_in;
   logic [EXSORT_IDX_W-1:0]  pj_ff, pj_in;
   logic [EXSORT_DATA_W-1:0] cur_ff, cur_in;
   logic [EXSORT_DATA_W-1:0] rd_ff;
   logic [EXSORT_DATA_W-1:0] out_data_ff, out_data_in;
   logic                     out_last_ff, out_last_in;
   logic                     out_ovf_ff, out_ovf_in;

   logic [EXSORT_DATA_W-1:0] mem [EXSORT_DEPTH];
   logic                     mem_we;
   logic [EXSORT_IDX_W-1:0]  mem_waddr;
   logic [EXSORT_DATA_W-1:0] mem_wdata;
   logic [EXSORT_IDX_W-1:0]  mem_raddr;

   logic                     req_acc;
   logic                     full;
   logic [EXSORT_CNT_W-1:0]  cnt_new;

   assign req_tready = (state_ff == ST_COLLECT);
   assign req_acc    = req_tvalid && req_tready;
   assign full       = (cnt_ff >= EXSORT_CNT_W'(EXSORT_DEPTH));
   assign cnt_new    = full ? cnt_ff : cnt_ff + 1'b1;

   assign rsp_tvalid   = (state_ff == ST_EM_OUT);
   assign rsp_tdata    = out_data_ff;
   assign rsp_tlast    = out_last_ff;
   assign rsp_tuser[0] = out_ovf_ff;

   assign cmp_req.held       = cur_ff;
   assign cmp_req.probe      = rd_ff;
   assign cmp_req.descending = desc_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      drop_in     = drop_ff;
      desc_in     = csr_we ? csr_wdata[0] : desc_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      pj_in       = pj_ff;
      cur_in      = cur_ff;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;
      out_ovf_in  = out_ovf_ff;
      mem_we      = 1'b0;
      mem_waddr   = i_ff;
      mem_wdata   = cur_ff;
      mem_raddr   = i_ff;

      unique case (state_ff)
         ST_COLLECT: begin
            if (req_acc) begin
               if (!full) begin
                  mem_we    = 1'b1;
                  mem_waddr = cnt_ff[EXSORT_IDX_W-1:0];
                  mem_wdata = req_tdata;
               end else begin
                  drop_in = 1'b1;
               end
               cnt_in = cnt_new;
               if (req_tlast) begin
                  i_in     = '0;
                  state_in = (cnt_new >= EXSORT_CNT_W'(2)) ? ST_LOAD : ST_EM_RD;
               end
            end
         end
         ST_LOAD: begin
            mem_raddr = i_ff;
            state_in  = ST_PRIME;
         end
         ST_PRIME: begin
            // rd_ff holds entry i, start reading the later entries
            cur_in    = rd_ff;
            mem_raddr = i_ff + 1'b1;
            pj_in     = i_ff + 1'b1;
            j_in      = EXSORT_CNT_W'(i_ff) + EXSORT_CNT_W'(2);
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            // rd_ff holds entry pj, one read issued each cycle while j < cnt
            if (cmp_swap) begin
               mem_we    = 1'b1;
               mem_waddr = pj_ff;
               mem_wdata = cur_ff;
               cur_in    = rd_ff;
            end
            if (j_ff < cnt_ff) begin
               mem_raddr = j_ff[EXSORT_IDX_W-1:0];
               pj_in     = j_ff[EXSORT_IDX_W-1:0];
               j_in      = j_ff + 1'b1;
            end else begin
               state_in = ST_WRI;
            end
         end
         ST_WRI: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = cur_ff;
            if (EXSORT_CNT_W'(i_ff) + EXSORT_CNT_W'(2) < cnt_ff) begin
               mem_raddr = i_ff + 1'b1;
               i_in      = i_ff + 1'b1;
               state_in  = ST_PRIME;
            end else begin
               i_in     = '0;
               state_in = ST_EM_RD;
            end
         end
         ST_EM_RD: begin
            mem_raddr = i_ff;
            state_in  = ST_EM_WAIT;
         end
         ST_EM_WAIT: begin
            out_data_in = rd_ff;
            out_last_in = (EXSORT_CNT_W'(i_ff) + 1'b1 == cnt_ff);
            out_ovf_in  = drop_ff;
            state_in    = ST_EM_OUT;
         end
         ST_EM_OUT: begin
            if (rsp_tready) begin
               if (out_last_ff) begin
                  cnt_in   = '0;
                  drop_in  = 1'b0;
                  i_in     = '0;
                  state_in = ST_COLLECT;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_EM_RD;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         cnt_ff   <= '0;
         drop_ff  <= 1'b0;
         desc_ff  <= 1'b0;
         i_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         drop_ff  <= drop_in;
         desc_ff  <= desc_in;
         i_ff     <= i_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff        <= j_in;
      pj_ff       <= pj_in;
      cur_ff      <= cur_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

endmodule

>>> src/exchange_sort_up_down.sv
// Collecting exchange sorter for signed 32-bit values.
// req channel: one value per item in req_tdata, req_tlast marks the last value
// of a set. Values are stored as they arrive, one per cycle; values beyond
// the 16-entry store are dropped and flagged.
// The item with req_tlast starts the sort of a set of n >= 2 stored values:
// one compare per cycle in a single comparator, bounded by the one-write,
// one-read store; a set of fewer values goes straight to the output.
// rsp channel: the n sorted values in order, rsp_tlast on the final one,
// rsp_tuser high on every result of a set that lost values. Each result goes
// through a store read, an output load and a handshake, one result at a time.
// While a set is sorted or emitted req_tready is low; a stalled receiver
// simply holds the current result and the block waits.
// csr_we/csr_wdata set the order: 0 ascending, 1 descending. Write only
// between sets.
// Reset (synchronous) empties the store, clears the overflow flag and selects
// ascending order; the block is ready for a new set in the next cycle.
module exchange_sort_up_down import exsort_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [EXSORT_DATA_W-1:0] req_tdata,   // [31:0] value
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [EXSORT_DATA_W-1:0] rsp_tdata,   // [31:0] sorted_value
   output logic                     rsp_tlast,
   output logic [0:0]               rsp_tuser,   // [0] overflow
   input  logic                     csr_we,
   input  logic [0:0]               csr_wdata
);

   exsort_cmp_req_type cmp_req;
   logic               cmp_swap;

   exsort_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmp_req    (cmp_req),
      .cmp_swap   (cmp_swap)
   );

   exsort_cmp u_cmp (
      .cmp_req  (cmp_req),
      .cmp_swap (cmp_swap)
   );

endmodule

>>> src/exsort_chk.sv
`include "exchange_sort_up_down_defines.svh"

module exsort_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [0:0]  rsp_tuser
);

   `EXSORT_ASSERT_NXT(a_reset_idle, clock, 1'b0, reset, req_tready && !rsp_tvalid, "not idle after reset")

   `EXSORT_ASSERT_NOW(a_no_overlap, clock, reset, rsp_tvalid, !req_tready, "input taken while a result is pending")

   `EXSORT_ASSERT_NXT(a_last_starts_sort, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready && !rsp_tvalid, "last item did not start the sort")

   `EXSORT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled result changed")

endmodule

bind exchange_sort_up_down exsort_chk u_exsort_chk (.*);
